// ----- src/pwt_pkg.sv -----
package pwt_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned LimitW = 31;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(1000000);

  localparam logic [CfgIdxW-1:0] CFG_EDGE_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAXIMUM_PULSE = 2'd1;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_AWAIT_LOW  = 3'd1,
    PH_AWAIT_RISE = 3'd2,
    PH_MEASURE    = 3'd3,
    PH_COMPLETE   = 3'd4,
    PH_TIMEOUT    = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [TimeW-1:0]   pulse_width;
    logic               level_seen;
    logic               done_res;
    logic               timed_out;
  } result_t;

endpackage

// ----- src/pwt_core.sv -----
module pwt_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic                           opcode,
  input  logic [pwt_pkg::TimeW-1:0]      now,
  input  logic                           level_high,
  input  logic [pwt_pkg::LimitW-1:0]     edge_timeout,
  input  logic [pwt_pkg::LimitW-1:0]     maximum_pulse,
  output pwt_pkg::result_t               result
);

  pwt_pkg::phase_t              phase_r, phase_nxt;
  logic [pwt_pkg::TimeW-1:0]    phase_start_r, phase_start_nxt;
  logic [pwt_pkg::TimeW-1:0]    pulse_start_r, pulse_start_nxt;
  logic [pwt_pkg::TimeW-1:0]    width_r, width_nxt;
  logic                         last_level_r;
  logic [pwt_pkg::TimeW-1:0]    edge_elapsed;
  logic [pwt_pkg::TimeW-1:0]    high_elapsed;
  logic                         edge_over;
  logic                         pulse_over;

  assign edge_elapsed = now - phase_start_r;
  assign high_elapsed = now - pulse_start_r;
  assign edge_over    = edge_elapsed > {1'b0, edge_timeout};
  assign pulse_over   = high_elapsed > {1'b0, maximum_pulse};

  always_comb begin
    phase_nxt       = phase_r;
    phase_start_nxt = phase_start_r;
    pulse_start_nxt = pulse_start_r;
    width_nxt       = width_r;
    if (opcode) begin
      phase_nxt       = level_high ? pwt_pkg::PH_AWAIT_LOW : pwt_pkg::PH_AWAIT_RISE;
      phase_start_nxt = now;
      pulse_start_nxt = now;
      width_nxt       = '0;
    end else begin
      unique case (phase_r)
        pwt_pkg::PH_AWAIT_LOW: begin
          if (!level_high) begin
            phase_nxt       = pwt_pkg::PH_AWAIT_RISE;
            phase_start_nxt = now;
          end else if (edge_over) begin
            phase_nxt = pwt_pkg::PH_TIMEOUT;
          end
        end
        pwt_pkg::PH_AWAIT_RISE: begin
          if (level_high) begin
            phase_nxt       = pwt_pkg::PH_MEASURE;
            pulse_start_nxt = now;
          end else if (edge_over) begin
            phase_nxt = pwt_pkg::PH_TIMEOUT;
          end
        end
        pwt_pkg::PH_MEASURE: begin
          if (!level_high) begin
            width_nxt = high_elapsed;
            phase_nxt = pwt_pkg::PH_COMPLETE;
          end else if (pulse_over) begin
            phase_nxt = pwt_pkg::PH_TIMEOUT;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_comb begin
    result.phase       = phase_nxt;
    result.pulse_width = width_nxt;
    result.level_seen  = level_high;
    result.done_res    = (phase_nxt == pwt_pkg::PH_COMPLETE);
    result.timed_out   = (phase_nxt == pwt_pkg::PH_TIMEOUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= pwt_pkg::PH_IDLE;
      phase_start_r <= '0;
      pulse_start_r <= '0;
      width_r       <= '0;
      last_level_r  <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      phase_start_r <= phase_start_nxt;
      pulse_start_r <= pulse_start_nxt;
      width_r       <= width_nxt;
      last_level_r  <= level_high;
    end
  end

  a_arm_waits: assert property (@(posedge clk) disable iff (!rst_n)
    accept && opcode |=> (phase_r == pwt_pkg::PH_AWAIT_LOW ||
                          phase_r == pwt_pkg::PH_AWAIT_RISE) && width_r == '0)
    else $error("arm did not start a wait with a cleared width");

  a_fall_completes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !opcode && !level_high && phase_r == pwt_pkg::PH_MEASURE
    |=> phase_r == pwt_pkg::PH_COMPLETE && width_r == $past(now - pulse_start_r))
    else $error("fall while measuring did not store the width");

  a_final_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !opcode && (phase_r == pwt_pkg::PH_COMPLETE ||
                          phase_r == pwt_pkg::PH_TIMEOUT || phase_r == pwt_pkg::PH_IDLE)
    |=> $stable(phase_r) && $stable(width_r) && last_level_r == $past(level_high))
    else $error("update changed a settled measurement");

endmodule

// ----- src/pwt_out_buf.sv -----
module pwt_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pwt_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output pwt_pkg::result_t  out_data
);

  logic             out_valid_r;
  logic             skid_valid_r;
  pwt_pkg::result_t out_data_r;
  pwt_pkg::result_t skid_data_r;
  logic             pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      out_valid_r <= 1'b1;
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r <= push_data;
      end else begin
        skid_data_r <= push_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("result pushed into a full buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && pop |=> out_valid_r && !skid_valid_r && out_data_r == $past(skid_data_r))
    else $error("skid entry not moved to the output");

endmodule

// ----- src/pulse_width_timer.sv -----
// A result is registered in the output buffer before it appears on out_*.
// Throughput: one transaction per cycle while in_stall is low; each timeout check is one subtract and compare.
// A two-entry result buffer lets input continue for one more transaction while the output is stalled.
// Reset (rst_n low, synchronous) sets the phase to idle, clears all timestamps and
// the width, empties the result buffer and loads both limits with 1000000.
module pulse_width_timer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [pwt_pkg::TimeW-1:0]      in_now,
  input  logic                           in_level_high,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_phase,
  output logic [pwt_pkg::TimeW-1:0]      out_pulse_width,
  output logic                           out_level_seen,
  output logic                           out_done_res,
  output logic                           out_timed_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pwt_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [pwt_pkg::LimitW-1:0]     cfg_data
);

  logic [pwt_pkg::LimitW-1:0] edge_timeout_r;
  logic [pwt_pkg::LimitW-1:0] maximum_pulse_r;
  logic                       in_accept;
  logic                       buf_full;
  pwt_pkg::result_t           core_result;
  pwt_pkg::result_t           out_result;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_timeout_r  <= pwt_pkg::LimitReset;
      maximum_pulse_r <= pwt_pkg::LimitReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pwt_pkg::CFG_EDGE_TIMEOUT:  edge_timeout_r  <= cfg_data;
        pwt_pkg::CFG_MAXIMUM_PULSE: maximum_pulse_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pwt_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .opcode        (in_opcode),
    .now           (in_now),
    .level_high    (in_level_high),
    .edge_timeout  (edge_timeout_r),
    .maximum_pulse (maximum_pulse_r),
    .result        (core_result)
  );

  pwt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (core_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_result)
  );

  assign out_phase       = 3'(out_result.phase);
  assign out_pulse_width = out_result.pulse_width;
  assign out_level_seen  = out_result.level_seen;
  assign out_done_res    = out_result.done_res;
  assign out_timed_out   = out_result.timed_out;

endmodule
